### rtl/core/ffba_pkg.sv
// Package for the first-fit block allocator: shared types, field widths and status codes.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package ffba_pkg;

  localparam int KIND_W = 1;
  localparam int REQ_W  = 14;
  localparam int BOFF_W = 13;
  localparam int STAT_W = 2;
  localparam int PAY_W  = 14;
  // A rounded request size needs one bit more than the raw request.
  localparam int NEED_W = REQ_W + 1;

  localparam logic [STAT_W-1:0] STAT_ALLOC = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FREED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NULL  = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_EVAL,
    ST_A_WR,
    ST_F_WR,
    ST_M_START,
    ST_M_CUR,
    ST_M_NXT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              init_wr;
    logic              load;
    logic              a_eval;
    logic              a_wr;
    logic              f_wr;
    logic              m_start;
    logic              m_cur;
    logic              m_nxt;
    logic              done;
    logic [STAT_W-1:0] done_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic kind_free;
    logic free_ok;
    logic fit;
    logic step_last;
    logic link_last;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/ffba_ctrl.sv
// Controller state machine of the first-fit block allocator.
// Depends on ffba_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module ffba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ffba_pkg::dp_stat_t stat,
  output ffba_pkg::dp_cmd_t       cmd,
  output logic                    busy
);
  import ffba_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (!stat.kind_free) begin
            state_next = ST_A_EVAL;
          end else if (stat.free_ok) begin
            state_next = ST_F_WR;
          end
        end
      end
      ST_A_EVAL: begin
        if (stat.fit) begin
          state_next = ST_A_WR;
        end else if (stat.step_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_A_WR: begin
        state_next = ST_IDLE;
      end
      ST_F_WR: begin
        state_next = ST_M_START;
      end
      ST_M_START: begin
        state_next = ST_M_CUR;
      end
      ST_M_CUR: begin
        state_next = stat.step_last ? ST_IDLE : ST_M_NXT;
      end
      ST_M_NXT: begin
        if (stat.link_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.done_status = STAT_ALLOC;
    case (state)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          // A null or out-of-pool free is answered at once.
          if (stat.kind_free && !stat.free_ok) begin
            cmd.done        = 1'b1;
            cmd.done_status = STAT_NULL;
          end
        end
      end
      ST_A_EVAL: begin
        cmd.a_eval = 1'b1;
        if (!stat.fit && stat.step_last) begin
          cmd.done        = 1'b1;
          cmd.done_status = STAT_NOFIT;
        end
      end
      ST_A_WR: begin
        cmd.a_wr        = 1'b1;
        cmd.done        = 1'b1;
        cmd.done_status = STAT_ALLOC;
      end
      ST_F_WR: begin
        cmd.f_wr = 1'b1;
      end
      ST_M_START: begin
        cmd.m_start = 1'b1;
      end
      ST_M_CUR: begin
        cmd.m_cur = 1'b1;
        if (stat.step_last) begin
          cmd.done        = 1'b1;
          cmd.done_status = STAT_FREED;
        end
      end
      ST_M_NXT: begin
        cmd.m_nxt = 1'b1;
        if (stat.link_last) begin
          cmd.done        = 1'b1;
          cmd.done_status = STAT_FREED;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/ffba_dp.sv
// Datapath of the first-fit block allocator: header memory, chain walk registers, result registers.
// Depends on ffba_pkg; sequenced by ffba_ctrl through dp_cmd_t.
`default_nettype none

module ffba_dp #(
  parameter int POOL_BYTES   = 8192,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [ffba_pkg::KIND_W-1:0]  kind,
  input  wire logic [ffba_pkg::REQ_W-1:0]   request_size,
  input  wire logic [ffba_pkg::BOFF_W-1:0]  block_offset,
  input  wire ffba_pkg::dp_cmd_t            cmd,
  output ffba_pkg::dp_stat_t                stat,
  output logic                              done,
  output logic [ffba_pkg::STAT_W-1:0]       status,
  output logic [ffba_pkg::PAY_W-1:0]        payload_offset
);
  import ffba_pkg::*;

  localparam int WORDS  = (POOL_BYTES + 3) / 4;
  localparam int IDX_W  = $clog2(WORDS);
  localparam int SIZE_W = $clog2(POOL_BYTES + 1);
  localparam int OFF_W  = $clog2(POOL_BYTES) + 2;
  localparam int SUM_W  = (OFF_W > NEED_W + 1) ? OFF_W : NEED_W + 1;
  localparam int ENT_W  = SIZE_W + 1;

  localparam logic [SUM_W-1:0]  POOL_C    = SUM_W'(POOL_BYTES);
  localparam logic [SUM_W-1:0]  HDR_C     = SUM_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0]  SPLIT_MIN = SUM_W'(HEADER_BYTES + 4);
  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(POOL_BYTES - HEADER_BYTES);

  // Each entry holds {free mark, payload size}.
  logic [ENT_W-1:0] mem [WORDS];
  logic [ENT_W-1:0] rdata;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [ENT_W-1:0] wdata;
  logic             we;

  logic [SUM_W-1:0]  cur;
  logic [SUM_W-1:0]  nxt_off;
  logic [NEED_W-1:0] need;
  logic [IDX_W-1:0]  fidx;
  logic              cur_free;
  logic [SIZE_W-1:0] cur_size;

  logic              rd_free;
  logic [SIZE_W-1:0] rd_size;
  logic [SUM_W-1:0]  rd_size_x;
  logic [SUM_W-1:0]  need_x;
  logic [SUM_W-1:0]  step;
  logic [SUM_W-1:0]  nxt_new;
  logic [SUM_W-1:0]  merged;
  logic [SUM_W-1:0]  rest;
  logic [SUM_W-1:0]  split_off;
  logic              split;
  logic              merge;
  logic [SUM_W-1:0]  boff_x;
  logic [SUM_W-1:0]  boff_hdr;
  logic [NEED_W-1:0] need_in;

  assign rd_free   = rdata[SIZE_W];
  assign rd_size   = rdata[SIZE_W-1:0];
  assign rd_size_x = SUM_W'(rd_size);
  assign need_x    = SUM_W'(need);

  assign step      = cur + HDR_C + rd_size_x;
  assign nxt_new   = nxt_off + HDR_C + rd_size_x;
  assign merged    = SUM_W'(cur_size) + HDR_C + rd_size_x;
  assign rest      = rd_size_x - need_x;
  assign split_off = cur + HDR_C + need_x;
  assign split     = (rest > SPLIT_MIN);
  assign merge     = cur_free && rd_free;

  assign boff_x   = SUM_W'(block_offset);
  assign boff_hdr = boff_x - HDR_C;
  assign need_in  = (NEED_W'(request_size) + NEED_W'(3)) & ~NEED_W'(3);

  assign stat.kind_free = (kind == KIND_FREE);
  assign stat.free_ok   = (boff_x >= HDR_C) && (boff_x < POOL_C);
  assign stat.fit       = rd_free && (rd_size_x >= need_x);
  assign stat.step_last = (step >= POOL_C);
  assign stat.link_last = (nxt_new >= POOL_C);

  always_comb begin
    if (cmd.load) begin
      raddr = stat.kind_free ? boff_hdr[IDX_W+1:2] : '0;
    end else if (cmd.a_eval || cmd.m_cur) begin
      raddr = step[IDX_W+1:2];
    end else if (cmd.m_nxt) begin
      raddr = nxt_new[IDX_W+1:2];
    end else if (cmd.m_start) begin
      raddr = '0;
    end else begin
      raddr = cur[IDX_W+1:2];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur[IDX_W+1:2];
    wdata = {1'b0, cur_size};
    if (cmd.init_wr) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {1'b1, INIT_SIZE};
    end else if (cmd.a_eval) begin
      // The remainder header goes in while the walk stands on the chosen block.
      we    = stat.fit && split && (split_off < POOL_C);
      waddr = split_off[IDX_W+1:2];
      wdata = {1'b1, SIZE_W'(rest - HDR_C)};
    end else if (cmd.a_wr) begin
      we    = 1'b1;
      waddr = cur[IDX_W+1:2];
      wdata = {1'b0, cur_size};
    end else if (cmd.f_wr) begin
      we    = 1'b1;
      waddr = fidx;
      wdata = {1'b1, rd_size};
    end else if (cmd.m_nxt) begin
      we    = merge;
      waddr = cur[IDX_W+1:2];
      wdata = {1'b1, SIZE_W'(merged)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur  <= '0;
      need <= need_in;
      fidx <= boff_hdr[IDX_W+1:2];
    end else if (cmd.a_eval) begin
      if (stat.fit) begin
        cur_size <= split ? SIZE_W'(need) : rd_size;
      end else begin
        cur <= step;
      end
    end else if (cmd.m_start) begin
      cur <= '0;
    end else if (cmd.m_cur) begin
      cur_free <= rd_free;
      cur_size <= rd_size;
      nxt_off  <= step;
    end else if (cmd.m_nxt) begin
      if (merge) begin
        cur_size <= SIZE_W'(merged);
      end else begin
        cur      <= nxt_off;
        cur_free <= rd_free;
        cur_size <= rd_size;
      end
      nxt_off <= nxt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status         <= cmd.done_status;
      payload_offset <= (cmd.done_status == STAT_ALLOC) ? PAY_W'(cur + HDR_C) : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: controller plus datapath with the header memory.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
//  channel   | handshake              | fields
//  ----------+------------------------+-------------------------------------
//  request   | start, busy            | kind, request_size, block_offset
//  result    | done (one-cycle pulse) | status, payload_offset
//
// An allocate walks the chain from the first header until a block fits, or over every header
// on the chain when nothing fits; a free marks its header free and then walks the whole chain,
// merging free neighbours as it goes. A null or out-of-pool free is answered without a walk.
// The header memory has one read port, so the walk visits one header per cycle.
// After reset the block writes the initial pool header in its init state, with busy high.
// Each result is on the ports for exactly one cycle while done is high; it cannot be stalled.
`default_nettype none

module first_fit_block_allocator #(
  parameter int POOL_BYTES   = 8192,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ffba_pkg::KIND_W-1:0]  kind,
  input  wire logic [ffba_pkg::REQ_W-1:0]   request_size,
  input  wire logic [ffba_pkg::BOFF_W-1:0]  block_offset,
  output logic                              done,
  output logic [ffba_pkg::STAT_W-1:0]       status,
  output logic [ffba_pkg::PAY_W-1:0]        payload_offset
);
  import ffba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffba_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .kind           (kind),
    .request_size   (request_size),
    .block_offset   (block_offset),
    .cmd            (cmd),
    .stat           (stat),
    .done           (done),
    .status         (status),
    .payload_offset (payload_offset)
  );

  // A result is only ever presented once the walk has finished.
  a_done_idle : assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result presented while busy");

  // An allocate request always starts a walk.
  a_alloc_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_ALLOC)) |=> busy)
    else $error("allocate request did not start a walk");

  // Only a successful allocate reports a nonzero payload offset.
  a_zero_pay : assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_ALLOC)) |-> (payload_offset == '0))
    else $error("payload offset nonzero without an allocation");

endmodule

`default_nettype wire

### tb/alloc_result_checker.sv
// Result checker for the first-fit block allocator: predicts every answer from its own
// copy of the block chain and compares it with what the block reports.
// Depends on ffba_pkg for field widths, request kinds and status codes.
module alloc_result_checker #(
  parameter int POOL_BYTES   = 8192,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic [ffba_pkg::KIND_W-1:0] kind,
  input  wire logic [ffba_pkg::REQ_W-1:0]  request_size,
  input  wire logic [ffba_pkg::BOFF_W-1:0] block_offset,
  input  wire logic                        done,
  input  wire logic [ffba_pkg::STAT_W-1:0] status,
  input  wire logic [ffba_pkg::PAY_W-1:0]  payload_offset,
  output int                               fail_count,
  output int                               pending,
  output int                               alloc_count,
  output int                               nofit_count,
  output int                               freed_count,
  output int                               ignored_count
);
  import ffba_pkg::*;

  localparam int WORDS = POOL_BYTES / 4;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAY_W-1:0]  payload;
  } alloc_result_t;

  // One header per pool word, as the block keeps them.
  int unsigned   hdr_size [WORDS];
  bit            hdr_free [WORDS];
  alloc_result_t expected_results [$];
  alloc_result_t want;

  function automatic void reset_pool();
    for (int i = 0; i < WORDS; i++) begin
      hdr_size[i] = 0;
      hdr_free[i] = 1'b0;
    end
    hdr_size[0] = POOL_BYTES - HEADER_BYTES;
    hdr_free[0] = 1'b1;
  endfunction

  // Walks the whole chain and folds each free block into a free predecessor.
  function automatic void coalesce_free_runs();
    int unsigned cur, ci, nxt, ni;
    cur = 0;
    while (cur < POOL_BYTES) begin
      ci  = cur >> 2;
      nxt = cur + HEADER_BYTES + hdr_size[ci];
      if (nxt >= POOL_BYTES) break;
      ni = nxt >> 2;
      if (hdr_free[ci] && hdr_free[ni]) hdr_size[ci] += HEADER_BYTES + hdr_size[ni];
      else cur = nxt;
    end
  endfunction

  function automatic alloc_result_t predict_request(logic [KIND_W-1:0] k,
                                                    logic [REQ_W-1:0] req,
                                                    logic [BOFF_W-1:0] off);
    alloc_result_t r;
    int unsigned   need, cur, idx, rest, nxt;
    r.status  = STAT_NOFIT;
    r.payload = '0;
    if (k == KIND_ALLOC) begin
      need = (32'(req) + 32'd3) & ~32'd3;
      cur  = 0;
      while (cur < POOL_BYTES) begin
        idx = cur >> 2;
        if (hdr_free[idx] && hdr_size[idx] >= need) begin
          rest = hdr_size[idx] - need;
          // The tail becomes a block of its own only when it is larger than a header plus four bytes.
          if (rest > HEADER_BYTES + 4) begin
            nxt = cur + HEADER_BYTES + need;
            if (nxt < POOL_BYTES) begin
              hdr_size[nxt >> 2] = rest - HEADER_BYTES;
              hdr_free[nxt >> 2] = 1'b1;
            end
            hdr_size[idx] = need;
          end
          hdr_free[idx] = 1'b0;
          r.status  = STAT_ALLOC;
          r.payload = PAY_W'(cur + HEADER_BYTES);
          return r;
        end
        cur += HEADER_BYTES + hdr_size[idx];
      end
    end else if (off == 0 || off < HEADER_BYTES || off >= POOL_BYTES) begin
      r.status = STAT_NULL;
    end else begin
      hdr_free[(32'(off) - HEADER_BYTES) >> 2] = 1'b1;
      coalesce_free_runs();
      r.status = STAT_FREED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_pool();
      expected_results.delete();
      fail_count    = 0;
      alloc_count   = 0;
      nofit_count   = 0;
      freed_count   = 0;
      ignored_count = 0;
    end else begin
      if (done) begin
        case (status)
          STAT_ALLOC: alloc_count++;
          STAT_NOFIT: nofit_count++;
          STAT_FREED: freed_count++;
          default:    ignored_count++;
        endcase
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request waiting, status %0d payload_offset %0d",
                   $time, status, payload_offset);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
          end
          if (payload_offset !== want.payload) begin
            fail_count++;
            $display("%0t: payload_offset mismatch, expected %0d, actual %0d",
                     $time, want.payload, payload_offset);
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_request(kind, request_size, block_offset));
    end
    pending = expected_results.size();
  end

endmodule

### tb/tb_top.sv
// Top of the first-fit block allocator testbench: clock, reset, request stimulus and verdict.
// Depends on ffba_pkg, first_fit_block_allocator and alloc_result_checker.
module tb_top;
  import ffba_pkg::*;

  localparam int     POOL_BYTES   = 8192;
  localparam int     HEADER_BYTES = 16;
  localparam int     WORDS        = POOL_BYTES / 4;
  localparam int     RANDOM_ITEMS = 1150;
  localparam int     CALM_ITEMS   = 150;
  // A free can walk every header of the chain and merge most of them.
  localparam int     DRAIN_CYCLES = 1200;
  localparam longint TIME_LIMIT   = 64'd40_000_000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [KIND_W-1:0]    kind = KIND_ALLOC;
  logic [REQ_W-1:0]     request_size = '0;
  logic [BOFF_W-1:0]    block_offset = '0;
  wire logic            busy;
  wire logic            done;
  wire logic [STAT_W-1:0] status;
  wire logic [PAY_W-1:0]  payload_offset;

  int fail_count, pending, alloc_count, nofit_count, freed_count, ignored_count;
  int sent = 0;

  // Payload offsets handed out and not yet returned by the stimulus.
  logic [BOFF_W-1:0] live_blocks [$];
  // Header indexes reported as block starts; each of them holds a written header.
  int unsigned       known_headers [$];
  bit                header_seen [WORDS];

  first_fit_block_allocator #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .request_size  (request_size),
    .block_offset  (block_offset),
    .done          (done),
    .status        (status),
    .payload_offset(payload_offset)
  );

  alloc_result_checker #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .request_size  (request_size),
    .block_offset  (block_offset),
    .done          (done),
    .status        (status),
    .payload_offset(payload_offset),
    .fail_count    (fail_count),
    .pending       (pending),
    .alloc_count   (alloc_count),
    .nofit_count   (nofit_count),
    .freed_count   (freed_count),
    .ignored_count (ignored_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin : watch_grants
    int unsigned idx;
    if (!rst && done && status == STAT_ALLOC &&
        payload_offset >= HEADER_BYTES && payload_offset < POOL_BYTES) begin
      idx = (32'(payload_offset) - HEADER_BYTES) >> 2;
      live_blocks.push_back(payload_offset[BOFF_W-1:0]);
      if (!header_seen[idx]) begin
        header_seen[idx] = 1'b1;
        known_headers.push_back(idx);
      end
    end
  end

  task automatic send_request(logic [KIND_W-1:0] k, logic [REQ_W-1:0] req,
                              logic [BOFF_W-1:0] off, bit idle_on);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    kind         <= k;
    request_size <= req;
    block_offset <= off;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin : stimulus
    int unsigned       roll, pick, idx, alloc_share, mode;
    int                j;
    bit                idle_on;
    logic [REQ_W-1:0]  req;
    logic [BOFF_W-1:0] off;

    header_seen[0] = 1'b1;
    known_headers.push_back(0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk through the corner cases on a known chain.
    send_request(KIND_ALLOC, 14'd0, 13'd0, 1'b0);        // zero size, split
    send_request(KIND_ALLOC, 14'd1, 13'h1fff, 1'b0);     // rounds up to 4
    send_request(KIND_ALLOC, 14'd3, 13'd0, 1'b0);
    send_request(KIND_ALLOC, 14'h3fff, 13'd0, 1'b0);     // largest request, no fit
    send_request(KIND_ALLOC, 14'd8192, 13'd0, 1'b0);
    send_request(KIND_ALLOC, 14'd8120, 13'd0, 1'b0);     // exact fit of the last block
    send_request(KIND_ALLOC, 14'd0, 13'd0, 1'b0);        // pool full
    send_request(KIND_FREE, 14'h3fff, 13'd0, 1'b0);      // null pointer
    send_request(KIND_FREE, 14'd0, 13'd15, 1'b0);        // below the first header
    send_request(KIND_FREE, 14'd0, 13'd32, 1'b1);
    send_request(KIND_FREE, 14'd0, 13'd53, 1'b1);        // unaligned, merges two blocks
    send_request(KIND_ALLOC, 14'd4, 13'd0, 1'b1);        // tail of header plus 4: no split
    send_request(KIND_FREE, 14'd0, 13'd32, 1'b1);
    send_request(KIND_ALLOC, 14'd0, 13'd0, 1'b1);        // tail one word larger: split
    send_request(KIND_FREE, 14'd0, 13'd52, 1'b1);        // stale header off the chain
    send_request(KIND_FREE, 14'd0, 13'd72, 1'b1);
    send_request(KIND_FREE, 14'd0, 13'd16, 1'b1);
    send_request(KIND_FREE, 14'd0, 13'd32, 1'b1);        // merges back to one pool block
    send_request(KIND_ALLOC, 14'd8176, 13'd0, 1'b1);     // whole pool
    send_request(KIND_FREE, 14'd0, 13'd16, 1'b1);
    send_request(KIND_ALLOC, 14'd8177, 13'd0, 1'b1);     // one word too many
    send_request(KIND_FREE, 14'd0, 13'd1, 1'b1);
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    live_blocks.delete();

    mode    = 0;
    idle_on = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Phases alternate between balanced traffic, filling the pool and draining it.
      if (n % 100 == 0) begin
        mode    = $urandom_range(0, 2);
        idle_on = (n < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      end
      alloc_share = (mode == 0) ? 50 : (mode == 1) ? 80 : 20;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_request(KIND_FREE, REQ_W'($urandom), BOFF_W'($urandom_range(0, HEADER_BYTES - 1)),
                     idle_on);
      end else if (roll < 10) begin
        idx = known_headers[$urandom_range(0, known_headers.size() - 1)];
        off = BOFF_W'(HEADER_BYTES + idx * 4 + $urandom_range(0, 3));
        send_request(KIND_FREE, REQ_W'($urandom), off, idle_on);
      end else if (roll < 10 + alloc_share * 90 / 100 || live_blocks.size() == 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 14)      req = REQ_W'($urandom_range(0, 256));
        else if (pick < 17) req = REQ_W'($urandom_range(0, 2048));
        else if (pick < 19) req = REQ_W'($urandom_range(0, 8192));
        else                req = REQ_W'($urandom);
        send_request(KIND_ALLOC, req, BOFF_W'($urandom), idle_on);
      end else begin
        j   = $urandom_range(0, live_blocks.size() - 1);
        off = live_blocks[j];
        live_blocks.delete(j);
        send_request(KIND_FREE, REQ_W'($urandom), off, idle_on);
      end
    end
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d allocations, %0d no-fit answers,", sent, alloc_count,
             nofit_count);
    $display("%0d frees and %0d ignored frees, over fill, drain and mixed phases.",
             freed_count, ignored_count);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
